### rtl/rgb_hsv_convert_8bit_macros.svh
// Assertion macros shared by the color conversion pipeline.
`ifndef RGB_HSV_CONVERT_8BIT_MACROS_SVH
`define RGB_HSV_CONVERT_8BIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");

`endif

### rtl/rhc_pkg.sv
// Shared types and constants of the RGB/HSV conversion pipeline.
`default_nettype none

package rhc_pkg;

    localparam int NDIV = 4;
    localparam int NSTG = NDIV + 4;

    localparam logic FUNC_TO_HSV = 1'b0;
    localparam logic FUNC_TO_RGB = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] in_first;
        logic [7:0] in_second;
        logic [7:0] in_third;
        logic [7:0] in_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic [7:0] out_third;
        logic [7:0] out_alpha;
    } t_out;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] v;
    } t_pipe_ctrl;

    typedef struct packed {
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] c3;
    } t_pix;

endpackage

`default_nettype wire

### rtl/rhc_div_step.sv
// Two restoring division steps of the pipelined 16-by-8 divider.
`default_nettype none

module rhc_div_step (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [7:0] i_den,
    input  logic [7:0] i_rem,
    input  logic [7:0] i_num,
    input  logic [7:0] i_quo,
    output logic [7:0] o_den,
    output logic [7:0] o_rem,
    output logic [7:0] o_num,
    output logic [7:0] o_quo
);

    logic [8:0] n_trial;
    logic [7:0] n_rem;
    logic [7:0] n_num;
    logic [7:0] n_quo;
    logic [7:0] r_den;
    logic [7:0] r_rem;
    logic [7:0] r_num;
    logic [7:0] r_quo;

    always_comb begin
        n_rem   = i_rem;
        n_num   = i_num;
        n_quo   = i_quo;
        n_trial = '0;
        for (int k = 0; k < 2; k++) begin
            n_trial = {n_rem, n_num[7]};
            n_num   = {n_num[6:0], 1'b0};
            if (n_trial >= {1'b0, i_den}) begin
                n_rem = 8'(n_trial - {1'b0, i_den});
                n_quo = {n_quo[6:0], 1'b1};
            end else begin
                n_rem = n_trial[7:0];
                n_quo = {n_quo[6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
        end
    end

    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

### rtl/rhc_rgb2hsv.sv
// RGB to HSV path: min/max, numerators, two pipelined dividers, hue assembly.
`default_nettype none
`include "rgb_hsv_convert_8bit_macros.svh"

module rhc_rgb2hsv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhc_pkg::t_pipe_ctrl i_ctrl,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output rhc_pkg::t_pix      o_pix
);

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;
    localparam logic [7:0] BASE_RED   = 8'd0;
    localparam logic [7:0] BASE_GREEN = 8'd85;
    localparam logic [7:0] BASE_BLUE  = 8'd171;
    localparam logic [7:0] HUE_SPAN   = 8'd43;
    localparam logic [15:0] HUE_MUL   = 16'd43;
    localparam int NDIV = rhc_pkg::NDIV;

    // stage 1
    logic [7:0] n_s1_mx;
    logic [7:0] n_s1_mn;
    logic [1:0] n_s1_sec;
    logic [8:0] n_s1_diff;
    logic [7:0] r_s1_mx;
    logic [7:0] r_s1_mn;
    logic [1:0] r_s1_sec;
    logic [8:0] r_s1_diff;

    // stage 2
    logic [7:0]  n_s2_delta;
    logic [7:0]  n_s2_absd;
    logic [15:0] n_s2_nums;
    logic [15:0] n_s2_numh;
    logic [7:0]  r_s2_mx;
    logic [7:0]  r_s2_delta;
    logic [1:0]  r_s2_sec;
    logic        r_s2_neg;
    logic [15:0] r_s2_nums;
    logic [15:0] r_s2_numh;

    // divider chain, index 0 is the stage 2 output
    logic [7:0] w_sden [NDIV+1];
    logic [7:0] w_srem [NDIV+1];
    logic [7:0] w_snum [NDIV+1];
    logic [7:0] w_squo [NDIV+1];
    logic [7:0] w_hden [NDIV+1];
    logic [7:0] w_hrem [NDIV+1];
    logic [7:0] w_hnum [NDIV+1];
    logic [7:0] w_hquo [NDIV+1];
    logic [1:0] w_sec  [NDIV+1];
    logic       w_neg  [NDIV+1];
    logic [1:0] r_dv_sec [NDIV];
    logic       r_dv_neg [NDIV];

    // final
    logic [7:0] n_base;
    logic [7:0] n_term;
    logic [7:0] n_hue;
    logic [7:0] n_sat;

    always_comb begin
        n_s1_mx = i_red;
        if (i_green > n_s1_mx) n_s1_mx = i_green;
        if (i_blue > n_s1_mx) n_s1_mx = i_blue;
        n_s1_mn = i_red;
        if (i_green < n_s1_mn) n_s1_mn = i_green;
        if (i_blue < n_s1_mn) n_s1_mn = i_blue;
        if (i_red == n_s1_mx) begin
            n_s1_sec  = SEC_RED;
            n_s1_diff = {1'b0, i_green} - {1'b0, i_blue};
        end else if (i_green == n_s1_mx) begin
            n_s1_sec  = SEC_GREEN;
            n_s1_diff = {1'b0, i_blue} - {1'b0, i_red};
        end else begin
            n_s1_sec  = SEC_BLUE;
            n_s1_diff = {1'b0, i_red} - {1'b0, i_green};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_s1_mx   <= n_s1_mx;
            r_s1_mn   <= n_s1_mn;
            r_s1_sec  <= n_s1_sec;
            r_s1_diff <= n_s1_diff;
        end
    end

    always_comb begin
        n_s2_delta = r_s1_mx - r_s1_mn;
        if (r_s1_diff[8]) begin
            n_s2_absd = 8'(~r_s1_diff + 9'd1);
        end else begin
            n_s2_absd = r_s1_diff[7:0];
        end
        n_s2_nums = {n_s2_delta, 8'd0} - {8'd0, n_s2_delta};
        n_s2_numh = {8'd0, n_s2_absd} * HUE_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r_s2_mx    <= r_s1_mx;
            r_s2_delta <= n_s2_delta;
            r_s2_sec   <= r_s1_sec;
            r_s2_neg   <= r_s1_diff[8];
            r_s2_nums  <= n_s2_nums;
            r_s2_numh  <= n_s2_numh;
        end
    end

    assign w_sden[0] = r_s2_mx;
    assign w_srem[0] = r_s2_nums[15:8];
    assign w_snum[0] = r_s2_nums[7:0];
    assign w_squo[0] = 8'd0;
    assign w_hden[0] = r_s2_delta;
    assign w_hrem[0] = r_s2_numh[15:8];
    assign w_hnum[0] = r_s2_numh[7:0];
    assign w_hquo[0] = 8'd0;
    assign w_sec[0]  = r_s2_sec;
    assign w_neg[0]  = r_s2_neg;

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        rhc_div_step u_sdiv (
            .i_clk (i_clk),
            .i_en  (i_ctrl.en[3+j]),
            .i_den (w_sden[j]),
            .i_rem (w_srem[j]),
            .i_num (w_snum[j]),
            .i_quo (w_squo[j]),
            .o_den (w_sden[j+1]),
            .o_rem (w_srem[j+1]),
            .o_num (w_snum[j+1]),
            .o_quo (w_squo[j+1])
        );

        rhc_div_step u_hdiv (
            .i_clk (i_clk),
            .i_en  (i_ctrl.en[3+j]),
            .i_den (w_hden[j]),
            .i_rem (w_hrem[j]),
            .i_num (w_hnum[j]),
            .i_quo (w_hquo[j]),
            .o_den (w_hden[j+1]),
            .o_rem (w_hrem[j+1]),
            .o_num (w_hnum[j+1]),
            .o_quo (w_hquo[j+1])
        );

        always_ff @(posedge i_clk) begin
            if (i_ctrl.en[3+j]) begin
                r_dv_sec[j] <= w_sec[j];
                r_dv_neg[j] <= w_neg[j];
            end
        end

        assign w_sec[j+1] = r_dv_sec[j];
        assign w_neg[j+1] = r_dv_neg[j];
    end

    always_comb begin
        case (w_sec[NDIV])
            SEC_RED:   n_base = BASE_RED;
            SEC_GREEN: n_base = BASE_GREEN;
            default:   n_base = BASE_BLUE;
        endcase
        if (w_neg[NDIV]) begin
            n_term = ~w_hquo[NDIV] + 8'd1;
        end else begin
            n_term = w_hquo[NDIV];
        end
        if (w_sden[NDIV] == 8'd0) begin
            n_sat = 8'd0;
            n_hue = 8'd0;
        end else begin
            n_sat = w_squo[NDIV];
            n_hue = (w_squo[NDIV] == 8'd0) ? 8'd0 : n_base + n_term;
        end
    end

    assign o_pix.c1 = n_hue;
    assign o_pix.c2 = n_sat;
    assign o_pix.c3 = w_sden[NDIV];

    `RHC_ASSERT_IMP(a_srem_below_den, i_ctrl.v[NDIV+2] && w_sden[NDIV] != 8'd0, w_srem[NDIV] < w_sden[NDIV])
    `RHC_ASSERT_IMP(a_hrem_below_den, i_ctrl.v[NDIV+2] && w_hden[NDIV] != 8'd0, w_hrem[NDIV] < w_hden[NDIV])
    `RHC_ASSERT_IMP(a_hue_term_span, i_ctrl.v[NDIV+2] && w_hden[NDIV] != 8'd0, w_hquo[NDIV] <= HUE_SPAN)

endmodule

`default_nettype wire

### rtl/rhc_hsv2rgb.sv
// HSV to RGB path: region split, two multiply rounds, channel select.
`default_nettype none

module rhc_hsv2rgb (
    input  logic               i_clk,
    input  rhc_pkg::t_pipe_ctrl i_ctrl,
    input  logic [7:0]         i_hue,
    input  logic [7:0]         i_sat,
    input  logic [7:0]         i_val,
    output rhc_pkg::t_pix      o_pix
);

    localparam logic [2:0] REG_0 = 3'd0;
    localparam logic [2:0] REG_1 = 3'd1;
    localparam logic [2:0] REG_2 = 3'd2;
    localparam logic [2:0] REG_3 = 3'd3;
    localparam logic [2:0] REG_4 = 3'd4;
    localparam logic [2:0] REG_5 = 3'd5;
    localparam logic [7:0] FULL  = 8'd255;

    // stage 1
    logic [2:0] n_s1_reg;
    logic [7:0] n_s1_off;
    logic [7:0] n_s1_frac;
    logic [2:0] r_s1_reg;
    logic [7:0] r_s1_rem;
    logic [7:0] r_s1_sat;
    logic [7:0] r_s1_val;

    // stage 2
    logic [15:0] r_s2_pp;
    logic [15:0] r_s2_x1;
    logic [15:0] r_s2_x2;
    logic [2:0]  r_s2_reg;
    logic [7:0]  r_s2_val;
    logic        r_s2_gray;

    // stage 3
    logic [7:0] r_s3_p;
    logic [7:0] r_s3_qf;
    logic [7:0] r_s3_tf;
    logic [2:0] r_s3_reg;
    logic [7:0] r_s3_val;
    logic       r_s3_gray;

    // stage 4
    logic [15:0] r_s4_qq;
    logic [15:0] r_s4_tt;
    logic [7:0]  r_s4_p;
    logic [2:0]  r_s4_reg;
    logic [7:0]  r_s4_val;
    logic        r_s4_gray;

    // stages 5 and 6
    rhc_pkg::t_pix n_s5_pix;
    rhc_pkg::t_pix r_s5_pix;
    rhc_pkg::t_pix r_s6_pix;
    logic [7:0]    w_q;
    logic [7:0]    w_t;

    always_comb begin
        n_s1_reg = REG_0;
        n_s1_off = 8'd0;
        if (i_hue >= 8'd43) begin
            n_s1_reg = REG_1;
            n_s1_off = 8'd43;
        end
        if (i_hue >= 8'd86) begin
            n_s1_reg = REG_2;
            n_s1_off = 8'd86;
        end
        if (i_hue >= 8'd129) begin
            n_s1_reg = REG_3;
            n_s1_off = 8'd129;
        end
        if (i_hue >= 8'd172) begin
            n_s1_reg = REG_4;
            n_s1_off = 8'd172;
        end
        if (i_hue >= 8'd215) begin
            n_s1_reg = REG_5;
            n_s1_off = 8'd215;
        end
        n_s1_frac = i_hue - n_s1_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r_s1_reg <= n_s1_reg;
            r_s1_rem <= {n_s1_frac[5:0], 2'b00} + {n_s1_frac[6:0], 1'b0};
            r_s1_sat <= i_sat;
            r_s1_val <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r_s2_pp   <= {8'd0, r_s1_val} * {8'd0, FULL - r_s1_sat};
            r_s2_x1   <= {8'd0, r_s1_sat} * {8'd0, r_s1_rem};
            r_s2_x2   <= {8'd0, r_s1_sat} * {8'd0, FULL - r_s1_rem};
            r_s2_reg  <= r_s1_reg;
            r_s2_val  <= r_s1_val;
            r_s2_gray <= (r_s1_sat == 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r_s3_p    <= r_s2_pp[15:8];
            r_s3_qf   <= FULL - r_s2_x1[15:8];
            r_s3_tf   <= FULL - r_s2_x2[15:8];
            r_s3_reg  <= r_s2_reg;
            r_s3_val  <= r_s2_val;
            r_s3_gray <= r_s2_gray;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[4]) begin
            r_s4_qq   <= {8'd0, r_s3_val} * {8'd0, r_s3_qf};
            r_s4_tt   <= {8'd0, r_s3_val} * {8'd0, r_s3_tf};
            r_s4_p    <= r_s3_p;
            r_s4_reg  <= r_s3_reg;
            r_s4_val  <= r_s3_val;
            r_s4_gray <= r_s3_gray;
        end
    end

    assign w_q = r_s4_qq[15:8];
    assign w_t = r_s4_tt[15:8];

    always_comb begin
        if (r_s4_gray) begin
            n_s5_pix = '{c1: r_s4_val, c2: r_s4_val, c3: r_s4_val};
        end else begin
            case (r_s4_reg)
                REG_0:   n_s5_pix = '{c1: r_s4_val, c2: w_t,      c3: r_s4_p};
                REG_1:   n_s5_pix = '{c1: w_q,      c2: r_s4_val, c3: r_s4_p};
                REG_2:   n_s5_pix = '{c1: r_s4_p,   c2: r_s4_val, c3: w_t};
                REG_3:   n_s5_pix = '{c1: r_s4_p,   c2: w_q,      c3: r_s4_val};
                REG_4:   n_s5_pix = '{c1: w_t,      c2: r_s4_p,   c3: r_s4_val};
                default: n_s5_pix = '{c1: r_s4_val, c2: r_s4_p,   c3: w_q};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[5]) begin
            r_s5_pix <= n_s5_pix;
        end
        if (i_ctrl.en[6]) begin
            r_s6_pix <= r_s5_pix;
        end
    end

    assign o_pix = r_s6_pix;

endmodule

`default_nettype wire

### rtl/rgb_hsv_convert_8bit.sv
// Top level of the 8-bit RGB/HSV pixel conversion pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  input   | in        | i_valid / o_stall  | i_data  (func, first..third, alpha)
//  output  | out       | o_valid / i_stall  | o_data  (first..third, alpha)
//
// One pixel transaction per cycle while i_stall is low; eight register stages
// from acceptance to o_valid, set by the four double-step stages of the dividers.
// Each stage advances when it is empty or the next one advances, so bubbles
// collapse and a stall holds in place each valid stage with no empty stage after it.
// Synchronous active-low reset clears the stage valid bits only.
`default_nettype none
`include "rgb_hsv_convert_8bit_macros.svh"

module rgb_hsv_convert_8bit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rhc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rhc_pkg::t_out o_data
);

    localparam int   LAST = rhc_pkg::NSTG - 1;

    logic [rhc_pkg::NSTG-1:0] r_v;
    logic [rhc_pkg::NSTG-1:0] w_en;
    rhc_pkg::t_pipe_ctrl      w_ctrl;
    rhc_pkg::t_in             r_in;
    logic                     r_func  [LAST];
    logic [7:0]               r_alpha [LAST];
    rhc_pkg::t_pix            w_hsv;
    rhc_pkg::t_pix            w_rgb;
    rhc_pkg::t_pix            n_pix;
    rhc_pkg::t_out            r_out;
    logic                     r_func_out;

    always_comb begin
        w_en[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_ctrl.en = w_en;
    assign w_ctrl.v  = r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_in       <= i_data;
            r_func[0]  <= i_data.func;
            r_alpha[0] <= i_data.in_alpha;
        end
        for (int k = 1; k < LAST; k++) begin
            if (w_en[k]) begin
                r_func[k]  <= r_func[k-1];
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    rhc_rgb2hsv u_rgb2hsv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_red   (r_in.in_first),
        .i_green (r_in.in_second),
        .i_blue  (r_in.in_third),
        .o_pix   (w_hsv)
    );

    rhc_hsv2rgb u_hsv2rgb (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_hue  (r_in.in_first),
        .i_sat  (r_in.in_second),
        .i_val  (r_in.in_third),
        .o_pix  (w_rgb)
    );

    assign n_pix = (r_func[LAST-1] == rhc_pkg::FUNC_TO_HSV) ? w_hsv : w_rgb;

    always_ff @(posedge i_clk) begin
        if (w_en[LAST]) begin
            r_out.out_first  <= n_pix.c1;
            r_out.out_second <= n_pix.c2;
            r_out.out_third  <= n_pix.c3;
            r_out.out_alpha  <= r_alpha[LAST-1];
            r_func_out       <= r_func[LAST-1];
        end
    end

    assign o_valid = r_v[LAST];
    assign o_data  = r_out;
    assign o_stall = !w_en[0];

    `RHC_ASSERT_NEXT(a_stage6_holds, r_v[LAST-1] && !w_en[LAST], r_v[LAST-1])
    `RHC_ASSERT_IMP(a_black_no_hue, o_valid && r_func_out == rhc_pkg::FUNC_TO_HSV && o_data.out_third == 8'd0, o_data.out_first == 8'd0 && o_data.out_second == 8'd0)
    `RHC_ASSERT_IMP(a_gray_no_hue, o_valid && r_func_out == rhc_pkg::FUNC_TO_HSV && o_data.out_second == 8'd0, o_data.out_first == 8'd0)

endmodule

`default_nettype wire

### bench/rgb_hsv_convert_8bit_tb.sv
// Self-checking testbench for the 8-bit RGB/HSV pixel conversion pipeline.
`default_nettype none

module rgb_hsv_convert_8bit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_RGB_TO_HSV = rhc_pkg::FUNC_TO_HSV;
    localparam logic FUNC_HSV_TO_RGB = rhc_pkg::FUNC_TO_RGB;
    localparam int   DIRECTED_ROWS   = 24;
    localparam int   RANDOM_ITEMS    = 1300;
    localparam int   HOLD_CYCLES     = 80;
    localparam int   HOLD_AFTER      = 500;
    localparam int   DRAIN_CYCLES    = 16;

    typedef struct {
        rhc_pkg::t_in  px;
        bit            typed;
        rhc_pkg::t_out want;
    } t_stim_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    rhc_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    rhc_pkg::t_out o_data;

    rhc_pkg::t_out pending_pixels[$];
    int   mismatch_count    = 0;
    int   pixels_accepted   = 0;
    int   pixels_checked    = 0;
    int   rgb_side_count    = 0;
    int   hsv_side_count    = 0;
    int   input_stall_count = 0;
    int   burst_left        = 0;
    bit   long_hold_active  = 1'b0;
    bit   long_hold_done    = 1'b0;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{'{FUNC_RGB_TO_HSV, 8'd0,   8'd0,   8'd0,   8'hA5}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'hA5}},
        '{'{FUNC_RGB_TO_HSV, 8'd255, 8'd255, 8'd255, 8'h00}, 1'b1, '{8'd0,   8'd0,   8'd255, 8'h00}},
        '{'{FUNC_RGB_TO_HSV, 8'd128, 8'd128, 8'd128, 8'hFF}, 1'b1, '{8'd0,   8'd0,   8'd128, 8'hFF}},
        '{'{FUNC_RGB_TO_HSV, 8'd255, 8'd0,   8'd0,   8'h5A}, 1'b1, '{8'd0,   8'd255, 8'd255, 8'h5A}},
        '{'{FUNC_RGB_TO_HSV, 8'd0,   8'd255, 8'd0,   8'h11}, 1'b1, '{8'd85,  8'd255, 8'd255, 8'h11}},
        '{'{FUNC_RGB_TO_HSV, 8'd0,   8'd0,   8'd255, 8'hEE}, 1'b1, '{8'd171, 8'd255, 8'd255, 8'hEE}},
        '{'{FUNC_RGB_TO_HSV, 8'd255, 8'd0,   8'd6,   8'h3C}, 1'b1, '{8'd255, 8'd255, 8'd255, 8'h3C}},
        '{'{FUNC_RGB_TO_HSV, 8'd1,   8'd0,   8'd0,   8'h01}, 1'b1, '{8'd0,   8'd255, 8'd1,   8'h01}},
        '{'{FUNC_RGB_TO_HSV, 8'd200, 8'd100, 8'd50,  8'h80}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_RGB_TO_HSV, 8'd10,  8'd200, 8'd199, 8'h7F}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_RGB_TO_HSV, 8'd30,  8'd60,  8'd250, 8'hC3}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_RGB_TO_HSV, 8'd250, 8'd250, 8'd10,  8'h3C}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd77,  8'd0,   8'd200, 8'h42}, 1'b1, '{8'd200, 8'd200, 8'd200, 8'h42}},
        '{'{FUNC_HSV_TO_RGB, 8'd0,   8'd0,   8'd0,   8'h00}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd255, 8'd255, 8'd255, 8'hFF}, 1'b1, '{8'd255, 8'd0,   8'd15,  8'hFF}},
        '{'{FUNC_HSV_TO_RGB, 8'd0,   8'd255, 8'd255, 8'h81}, 1'b1, '{8'd255, 8'd0,   8'd0,   8'h81}},
        '{'{FUNC_HSV_TO_RGB, 8'd42,  8'd200, 8'd180, 8'h18}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd43,  8'd255, 8'd128, 8'h24}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd86,  8'd128, 8'd255, 8'h99}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd129, 8'd77,  8'd90,  8'h66}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd172, 8'd255, 8'd40,  8'hDB}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd214, 8'd1,   8'd255, 8'h0F}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd215, 8'd254, 8'd254, 8'hF0}, 1'b0, '{8'd0,   8'd0,   8'd0,   8'h00}},
        '{'{FUNC_HSV_TO_RGB, 8'd100, 8'd255, 8'd0,   8'h55}, 1'b1, '{8'd0,   8'd0,   8'd0,   8'h55}}
    };

    rgb_hsv_convert_8bit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic rhc_pkg::t_out convert_pixel(input rhc_pkg::t_in px);
        rhc_pkg::t_out res;
        int   r, g, b, mx, mn, delta, base, diff, hue, sat;
        int   region, rem, p, q, t;
        r = px.in_first;
        g = px.in_second;
        b = px.in_third;
        res.out_alpha = px.in_alpha;
        if (px.func == FUNC_RGB_TO_HSV) begin
            mx = (r > g) ? r : g;
            mx = (b > mx) ? b : mx;
            mn = (r < g) ? r : g;
            mn = (b < mn) ? b : mn;
            delta = mx - mn;
            hue = 0;
            sat = 0;
            if (mx != 0) begin
                sat = (255 * delta) / mx;
                if (sat != 0) begin
                    if (r == mx) begin
                        base = 0;
                        diff = g - b;
                    end else if (g == mx) begin
                        base = 85;
                        diff = b - r;
                    end else begin
                        base = 171;
                        diff = r - g;
                    end
                    hue = (base + (43 * diff) / delta) & 255;
                end
            end
            res.out_first  = 8'(hue);
            res.out_second = 8'(sat);
            res.out_third  = 8'(mx);
        end else if (g == 0) begin
            res.out_first  = 8'(b);
            res.out_second = 8'(b);
            res.out_third  = 8'(b);
        end else begin
            region = r / 43;
            if (region > 5) region = 5;
            rem = ((r - region * 43) * 6) & 255;
            p = (b * (255 - g)) >> 8;
            q = (b * (255 - ((g * rem) >> 8))) >> 8;
            t = (b * (255 - ((g * (255 - rem)) >> 8))) >> 8;
            case (region)
                0: begin res.out_first = 8'(b); res.out_second = 8'(t); res.out_third = 8'(p); end
                1: begin res.out_first = 8'(q); res.out_second = 8'(b); res.out_third = 8'(p); end
                2: begin res.out_first = 8'(p); res.out_second = 8'(b); res.out_third = 8'(t); end
                3: begin res.out_first = 8'(p); res.out_second = 8'(q); res.out_third = 8'(b); end
                4: begin res.out_first = 8'(t); res.out_second = 8'(p); res.out_third = 8'(b); end
                default: begin
                    res.out_first = 8'(b); res.out_second = 8'(p); res.out_third = 8'(q);
                end
            endcase
        end
        return res;
    endfunction

    function automatic rhc_pkg::t_in random_pixel();
        rhc_pkg::t_in px;
        logic [7:0]   level;
        px.func      = ($urandom_range(0, 1) != 0) ? FUNC_HSV_TO_RGB : FUNC_RGB_TO_HSV;
        px.in_first  = 8'($urandom);
        px.in_second = 8'($urandom);
        px.in_third  = 8'($urandom);
        px.in_alpha  = 8'($urandom);
        level        = 8'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                px.in_first  = level;
                px.in_second = level;
                px.in_third  = level;
            end
            1: px.in_second = px.in_first;
            2: px.in_third  = px.in_second;
            3: px.in_third  = px.in_first;
            4: begin
                px.in_first  = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                px.in_second = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                px.in_third  = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            5: begin
                px.in_first  = 8'($urandom_range(0, 3));
                px.in_second = 8'($urandom_range(0, 3));
                px.in_third  = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_pixel(input rhc_pkg::t_in px, input bit typed,
                              input rhc_pkg::t_out want);
        int gap;
        if (burst_left == 0 && !long_hold_active) begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 32);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_data  <= rhc_pkg::t_in'($urandom);
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_pixels.insert(pending_pixels.size(), typed ? want : convert_pixel(px));
        pixels_accepted++;
        if (px.func == FUNC_RGB_TO_HSV) rgb_side_count++;
        else hsv_side_count++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        rhc_pkg::t_out expected_px;
        string         field_names [4];
        field_names = '{"first", "second", "third", "alpha"};
        if (i_rst_n && i_valid && o_stall) input_stall_count++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_data));
            end else begin
                expected_px = pending_pixels.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (o_data[31-8*k -: 8] !== expected_px[31-8*k -: 8])
                        report_mismatch($sformatf("result %0d out_%s got %0d want %0d",
                            pixels_checked, field_names[k], o_data[31-8*k -: 8],
                            expected_px[31-8*k -: 8]));
                end
                pixels_checked++;
            end
        end
    end

    initial begin
        int seg_len;
        int mode;
        int tick;
        i_stall = 1'b0;
        tick = 0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!long_hold_done && pixels_accepted >= HOLD_AFTER) begin
                long_hold_active = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_active = 1'b0;
                long_hold_done = 1'b1;
            end else begin
                seg_len = $urandom_range(20, 120);
                mode = $urandom_range(0, 3);
                repeat (seg_len) begin
                    case (mode)
                        0: i_stall <= 1'b0;
                        1: i_stall <= ($urandom_range(0, 3) == 0);
                        2: i_stall <= ($urandom_range(0, 1) != 0);
                        default: i_stall <= (tick % 5 >= 3);
                    endcase
                    tick++;
                    @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending_pixels.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        rhc_pkg::t_out no_result;
        no_result = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int row = 0; row < DIRECTED_ROWS; row++)
            send_pixel(directed_rows[row].px, directed_rows[row].typed,
                       directed_rows[row].want);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_pixel(random_pixel(), 1'b0, no_result);
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
        $display("Sent %0d pixels (%0d RGB to HSV, %0d HSV to RGB), checked %0d results",
                 pixels_accepted, rgb_side_count, hsv_side_count, pixels_checked);
        $display("Output held off %0d cycles once; input stalled on %0d cycles, %0d mismatches",
                 HOLD_CYCLES, input_stall_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
